// File: hw/rtl/bwd_pkg.sv
// Package for the button window debouncer: sizes, command and event codes,
// register indexes and the result record.
// No dependencies; the core takes everything here by scoped names.
package bwd_pkg;

   // Sample window length and width of the wrapping totals.
   localparam int WINDOW_BITS = 8;
   localparam int TOTAL_WIDTH = 16;

   // Ones count must hold the value WINDOW_BITS itself.
   localparam int ONES_W = $clog2(WINDOW_BITS + 1);
   localparam int PRESS_TH_W = 4;
   localparam int RELEASE_TH_W = 3;
   localparam int LENGTH_W = 16;
   localparam int CMP_W = (ONES_W > PRESS_TH_W) ? ONES_W : PRESS_TH_W;

   // Port widths.
   localparam int OUT_TOTAL_W = 16;
   localparam int CMD_W = 2;
   localparam int EVENT_W = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_FIELDS_W = 1 + 3 * OUT_TOTAL_W;
   localparam int RSP_DATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_USER_W = EVENT_W + 1;

   // Commands.
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ARM   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

   // Events.
   localparam logic [EVENT_W-1:0] EV_NONE    = 2'd0;
   localparam logic [EVENT_W-1:0] EV_PRESS   = 2'd1;
   localparam logic [EVENT_W-1:0] EV_RELEASE = 2'd2;

   // Register indexes.
   localparam logic [CSR_ADDR_W-1:0] REG_PRESS_TH   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_RELEASE_TH = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_REFRACTORY = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_CHATTER    = 2'd3;

   typedef struct packed {
      logic [EVENT_W-1:0]     event_res;
      logic                   stale_flag;
      logic                   debounced_level;
      logic [OUT_TOTAL_W-1:0] press_total;
      logic [OUT_TOTAL_W-1:0] release_total;
      logic [OUT_TOTAL_W-1:0] stale_total;
   } rsp_type;

endpackage

// File: hw/rtl/button_window_debouncer_core.sv
// Each result is registered in the output register, or in the skid entry while the output is held.
// Throughput: one request per cycle while req_tready is high; the state registers update on each request transfer.
// A two-entry result buffer (output register plus skid) keeps requests flowing while the
// result side stalls; ready drops only when both entries are full.
// Reset is synchronous and active high: all counters, window, level and marker go to zero,
// and the registers return to thresholds 6 and 2, refractory 100 and chatter 50.
// Uses bwd_pkg for sizes, codes and the result record.
module button_window_debouncer_core (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bwd_pkg::REQ_DATA_W-1:0]      req_tdata,  // [0] pressed_sample, rest zero
   input  logic [bwd_pkg::CMD_W-1:0]           req_tuser,  // [1:0] cmd
   // Result channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] debounced_level, [16:1] press_total, [32:17] release_total,
   // [48:33] stale_total, rest zero
   output logic [bwd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [bwd_pkg::RSP_USER_W-1:0]      rsp_tuser,  // [1:0] event_res, [2] stale_flag
   // Configuration writes.
   input  logic                                csr_we,
   input  logic [bwd_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [bwd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int W  = bwd_pkg::WINDOW_BITS;
   localparam int TW = bwd_pkg::TOTAL_WIDTH;
   localparam int OW = bwd_pkg::ONES_W;
   localparam int CW = bwd_pkg::CMP_W;
   localparam int LW = bwd_pkg::LENGTH_W;

   // Configuration registers.
   logic [bwd_pkg::PRESS_TH_W-1:0]   press_th_ff;
   logic [bwd_pkg::RELEASE_TH_W-1:0] release_th_ff;
   logic [LW-1:0]                    refractory_len_ff;
   logic [LW-1:0]                    chatter_len_ff;

   // Debouncer state.
   logic [W-1:0]  window_ff,     window_in;
   logic [OW-1:0] ones_ff,       ones_in;
   logic          level_ff,      level_in;
   logic [LW-1:0] refractory_ff, refractory_in;
   logic [LW-1:0] chatter_ff,    chatter_in;
   logic          marker_ff,     marker_in;
   logic [TW-1:0] press_cnt_ff,  press_cnt_in;
   logic [TW-1:0] release_cnt_ff, release_cnt_in;
   logic [TW-1:0] stale_cnt_ff,  stale_cnt_in;

   // Result buffer.
   logic                 out_valid_ff,  skid_valid_ff;
   bwd_pkg::rsp_type     out_ff,        skid_ff;
   bwd_pkg::rsp_type     result;

   logic                       accept;
   logic                       pop;
   logic                       raw;
   logic [bwd_pkg::CMD_W-1:0]  cmd;
   logic [LW-1:0]              chatter_dec;
   logic [LW-1:0]              refractory_dec;
   logic [OW-1:0]              ones_shift;
   logic                       press_hit;
   logic                       release_hit;
   logic [bwd_pkg::EVENT_W-1:0] ev;
   logic                       flag;
   logic                       press_inc;
   logic                       release_inc;
   logic                       stale_inc;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;
   assign raw        = req_tdata[0];
   assign cmd        = req_tuser;

   // Cooldowns count down first, then the window shifts in the new sample.
   assign chatter_dec    = (chatter_ff != '0) ? chatter_ff - LW'(1) : chatter_ff;
   assign refractory_dec = (refractory_ff != '0) ? refractory_ff - LW'(1) : refractory_ff;
   assign ones_shift     = ones_ff + OW'(raw) - OW'(window_ff[W-1]);
   assign press_hit      = !level_ff && (CW'(ones_shift) >= CW'(press_th_ff));
   assign release_hit    = level_ff && (CW'(ones_shift) <= CW'(release_th_ff));

   always_comb begin
      window_in     = window_ff;
      ones_in       = ones_ff;
      level_in      = level_ff;
      refractory_in = refractory_ff;
      chatter_in    = chatter_ff;
      marker_in     = marker_ff;
      ev            = bwd_pkg::EV_NONE;
      flag          = 1'b0;
      press_inc     = 1'b0;
      release_inc   = 1'b0;
      stale_inc     = 1'b0;
      unique case (cmd)
         bwd_pkg::CMD_TICK: begin
            window_in     = {window_ff[W-2:0], raw};
            ones_in       = ones_shift;
            refractory_in = refractory_dec;
            chatter_in    = chatter_dec;
            if (press_hit) begin
               level_in = 1'b1;
               // A press inside the refractory time only counts as stale.
               if (refractory_dec != '0) begin
                  stale_inc = 1'b1;
               end else begin
                  refractory_in = refractory_len_ff;
                  press_inc     = 1'b1;
                  ev            = bwd_pkg::EV_PRESS;
               end
            end else if (release_hit) begin
               level_in    = 1'b0;
               release_inc = 1'b1;
               ev          = bwd_pkg::EV_RELEASE;
            end
            // Stale filter on the event of this tick.
            if (!marker_ff) begin
               if (ev == bwd_pkg::EV_PRESS && chatter_dec != '0) begin
                  stale_inc = 1'b1;
                  flag      = 1'b1;
               end
            end else if (ev == bwd_pkg::EV_PRESS) begin
               marker_in  = 1'b0;
               chatter_in = chatter_len_ff;
               stale_inc  = 1'b1;
               flag       = 1'b1;
            end else if (ev == bwd_pkg::EV_RELEASE || (!level_in && ones_shift == '0)) begin
               marker_in  = 1'b0;
               chatter_in = chatter_len_ff;
            end
         end
         bwd_pkg::CMD_ARM: begin
            marker_in = level_ff || (ones_ff != '0);
         end
         bwd_pkg::CMD_CLEAR: begin
            marker_in     = 1'b0;
            chatter_in    = '0;
            refractory_in = '0;
         end
         bwd_pkg::CMD_NOP: begin
         end
         default: begin
         end
      endcase
   end

   assign press_cnt_in   = press_inc   ? press_cnt_ff   + TW'(1) : press_cnt_ff;
   assign release_cnt_in = release_inc ? release_cnt_ff + TW'(1) : release_cnt_ff;
   assign stale_cnt_in   = stale_inc   ? stale_cnt_ff   + TW'(1) : stale_cnt_ff;

   always_comb begin
      result.event_res       = ev;
      result.stale_flag      = flag;
      result.debounced_level = level_in;
      result.press_total     = bwd_pkg::OUT_TOTAL_W'(press_cnt_in);
      result.release_total   = bwd_pkg::OUT_TOTAL_W'(release_cnt_in);
      result.stale_total     = bwd_pkg::OUT_TOTAL_W'(stale_cnt_in);
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         press_th_ff       <= bwd_pkg::PRESS_TH_W'(6);
         release_th_ff     <= bwd_pkg::RELEASE_TH_W'(2);
         refractory_len_ff <= LW'(100);
         chatter_len_ff    <= LW'(50);
      end else if (csr_we) begin
         unique case (csr_addr)
            bwd_pkg::REG_PRESS_TH:   press_th_ff       <= csr_wdata[bwd_pkg::PRESS_TH_W-1:0];
            bwd_pkg::REG_RELEASE_TH: release_th_ff     <= csr_wdata[bwd_pkg::RELEASE_TH_W-1:0];
            bwd_pkg::REG_REFRACTORY: refractory_len_ff <= csr_wdata[LW-1:0];
            bwd_pkg::REG_CHATTER:    chatter_len_ff    <= csr_wdata[LW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Debouncer state advances on every request transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= '0;
         ones_ff        <= '0;
         level_ff       <= 1'b0;
         refractory_ff  <= '0;
         chatter_ff     <= '0;
         marker_ff      <= 1'b0;
         press_cnt_ff   <= '0;
         release_cnt_ff <= '0;
         stale_cnt_ff   <= '0;
      end else if (accept) begin
         window_ff      <= window_in;
         ones_ff        <= ones_in;
         level_ff       <= level_in;
         refractory_ff  <= refractory_in;
         chatter_ff     <= chatter_in;
         marker_ff      <= marker_in;
         press_cnt_ff   <= press_cnt_in;
         release_cnt_ff <= release_cnt_in;
         stale_cnt_ff   <= stale_cnt_in;
      end
   end

   // Result buffer: the skid entry fills only when the output register is held.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (accept) begin
         if (out_valid_ff && !pop) begin
            skid_ff <= result;
         end else begin
            out_ff <= result;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = {out_ff.stale_flag, out_ff.event_res};
   assign rsp_tdata  = bwd_pkg::RSP_DATA_W'({out_ff.stale_total, out_ff.release_total,
                                             out_ff.press_total, out_ff.debounced_level});

endmodule
